/* rtl/math_expression_lexer_assert.svh */
// Assertion macros for the expression lexer.
// Used by the top level; no other dependencies.
`ifndef MATH_EXPRESSION_LEXER_ASSERT_SVH
`define MATH_EXPRESSION_LEXER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MEL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lexer assertion failed");

// next-cycle implication, disabled during reset
`define MEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lexer assertion failed");

`endif

/* rtl/mel_pkg.sv */
// Shared types, constants and character classifier of the expression lexer.
// No dependencies.
`default_nettype none

package mel_pkg;

  localparam int TOKEN_CHARS = 16;
  localparam int STORE_DEPTH = 16;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [2:0] K_LITERAL  = 3'd0;
  localparam logic [2:0] K_VARIABLE = 3'd1;
  localparam logic [2:0] K_OPERATOR = 3'd2;
  localparam logic [2:0] K_FUNCTION = 3'd3;
  localparam logic [2:0] K_LPAREN   = 3'd4;
  localparam logic [2:0] K_RPAREN   = 3'd5;
  localparam logic [2:0] K_DELIM    = 3'd6;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_LETTER,
    CLS_OP,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_COMMA,
    CLS_OTHER
  } cls_e;

  typedef enum logic [1:0] {
    SRC_NUM,
    SRC_LET,
    SRC_STAR,
    SRC_SELF
  } src_e;

  typedef struct packed {
    logic             accept;
    logic             load;
    src_e             src;
    logic [2:0]       kind;
    logic [IDX_W-1:0] idx;
    logic             tok_end;
    logic             run_last;
    logic             clr_num;
    logic             clr_let;
    logic             clr_ovf;
  } cmd_t;

  typedef struct packed {
    cls_e             cls;
    logic [CNT_W-1:0] num_cnt;
    logic [CNT_W-1:0] let_cnt;
    logic             slot_free;
  } sts_t;

  function automatic cls_e classify(input logic [7:0] ch);
    cls_e c;
    c = CLS_OTHER;
    if ((ch >= 8'h30 && ch <= 8'h39) || ch == CH_DOT) c = CLS_DIGIT;
    else if ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A)) c = CLS_LETTER;
    else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR ||
             ch == CH_SLASH || ch == CH_CARET) c = CLS_OP;
    else if (ch == CH_LPAREN) c = CLS_LPAREN;
    else if (ch == CH_RPAREN) c = CLS_RPAREN;
    else if (ch == CH_COMMA) c = CLS_COMMA;
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/math_expression_lexer.sv */
// Expression lexer: one input item per character, one result per token character.
// An item is taken while the controller is idle; its results pass the phase register
// and then the output register. Each item gives R results (0..48), and the controller
// emits one result per cycle while the output is not stalled, input stalled meanwhile.
// Reset (rst_ni low, async): counts, overflow flag, controller and output valid clear;
// store contents are not cleared. Uses mel_pkg, mel_ctrl, mel_datapath.
`default_nettype none

`include "math_expression_lexer_assert.svh"

module math_expression_lexer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       is_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      token_kind_o,
  output logic [7:0]      token_char_o,
  output logic            token_end_o,
  output logic            run_last_o,
  output logic            truncated_o
);
  import mel_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .is_end_i   (is_end_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mel_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_char_i    (in_char_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .token_kind_o (token_kind_o),
    .token_char_o (token_char_o),
    .token_end_o  (token_end_o),
    .run_last_o   (run_last_o),
    .truncated_o  (truncated_o)
  );

  `MEL_ASSERT_NOW(a_no_accept_while_emit, clk_i, rst_ni, cmd.accept, !cmd.load)
  `MEL_ASSERT_NEXT(a_reopen_after_last, clk_i, rst_ni, cmd.load && cmd.run_last, !in_stall_o)
  `MEL_ASSERT_NOW(a_flush_nonempty, clk_i, rst_ni, cmd.clr_num, sts.num_cnt != '0)
  `MEL_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, cmd.load, out_valid_o)

endmodule

`default_nettype wire

/* rtl/mel_datapath.sv */
// Datapath of the expression lexer: number and letter stores, counts,
// overflow flag, captured character and output register. Uses mel_pkg.
`default_nettype none

module mel_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    in_char_i,
  input  wire mel_pkg::cmd_t cmd_i,
  output mel_pkg::sts_t      sts_o,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output logic [2:0]         token_kind_o,
  output logic [7:0]         token_char_o,
  output logic               token_end_o,
  output logic               run_last_o,
  output logic               truncated_o
);
  import mel_pkg::*;

  logic [7:0]       num_mem_q [STORE_DEPTH];
  logic [7:0]       let_mem_q [STORE_DEPTH];
  logic [CNT_W-1:0] num_cnt_q, num_cnt_d;
  logic [CNT_W-1:0] let_cnt_q, let_cnt_d;
  logic             ovf_q, ovf_d;
  logic [7:0]       char_q;
  logic             out_valid_q, out_valid_d;
  logic [2:0]       kind_q;
  logic [7:0]       tchar_q, tchar_d;
  logic             tend_q, rlast_q, trunc_q;
  cls_e             in_cls;
  logic             num_full, let_full;

  assign in_cls   = classify(in_char_i);
  assign num_full = (num_cnt_q >= CNT_W'(TOKEN_CHARS));
  assign let_full = (let_cnt_q >= CNT_W'(TOKEN_CHARS));

  always_comb begin
    num_cnt_d = num_cnt_q;
    let_cnt_d = let_cnt_q;
    ovf_d     = ovf_q;
    if (cmd_i.accept && in_cls == CLS_DIGIT) begin
      if (num_full) ovf_d = 1'b1;
      else num_cnt_d = num_cnt_q + CNT_W'(1);
    end
    if (cmd_i.accept && in_cls == CLS_LETTER) begin
      if (let_full) ovf_d = 1'b1;
      else let_cnt_d = let_cnt_q + CNT_W'(1);
    end
    if (cmd_i.clr_num) num_cnt_d = '0;
    if (cmd_i.clr_let) let_cnt_d = '0;
    if (cmd_i.clr_ovf) ovf_d = 1'b0;
  end

  always_comb begin
    unique case (cmd_i.src)
      SRC_NUM:  tchar_d = num_mem_q[cmd_i.idx];
      SRC_LET:  tchar_d = let_mem_q[cmd_i.idx];
      SRC_STAR: tchar_d = CH_STAR;
      SRC_SELF: tchar_d = char_q;
      default:  tchar_d = char_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cnt_q   <= '0;
      let_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      num_cnt_q   <= num_cnt_d;
      let_cnt_q   <= let_cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stores and payload: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) char_q <= in_char_i;
    if (cmd_i.accept && in_cls == CLS_DIGIT && !num_full) begin
      num_mem_q[num_cnt_q[IDX_W-1:0]] <= in_char_i;
    end
    if (cmd_i.accept && in_cls == CLS_LETTER && !let_full) begin
      let_mem_q[let_cnt_q[IDX_W-1:0]] <= in_char_i;
    end
    if (cmd_i.load) begin
      kind_q  <= cmd_i.kind;
      tchar_q <= tchar_d;
      tend_q  <= cmd_i.tok_end;
      rlast_q <= cmd_i.run_last;
      trunc_q <= ovf_q;
    end
  end

  assign sts_o.cls       = in_cls;
  assign sts_o.num_cnt   = num_cnt_q;
  assign sts_o.let_cnt   = let_cnt_q;
  assign sts_o.slot_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign token_kind_o = kind_q;
  assign token_char_o = tchar_q;
  assign token_end_o  = tend_q;
  assign run_last_o   = rlast_q;
  assign truncated_o  = trunc_q;

endmodule

`default_nettype wire

/* rtl/mel_ctrl.sv */
// Controller of the expression lexer: plans the flush phases of an item and
// steps through them one result per cycle while the output can take one. Uses mel_pkg.
`default_nettype none

module mel_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          is_end_i,
  output logic               in_stall_o,
  input  wire mel_pkg::sts_t sts_i,
  output mel_pkg::cmd_t      cmd_o
);
  import mel_pkg::*;

  // phase codes, in emission order
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LETA = 3'd1; // letters before number: ')' or function name
  localparam logic [2:0] S_NUM  = 3'd2;
  localparam logic [2:0] S_STAR = 3'd3;
  localparam logic [2:0] S_LETB = 3'd4;
  localparam logic [2:0] S_SELF = 3'd5;
  localparam logic [2:0] S_ENUM = 3'd6;
  localparam logic [2:0] S_ELET = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [6:0]       mask_q, mask_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             star_q, star_d;
  logic             end_q, end_d;
  cls_e             cls_q, cls_d;

  logic             n_nz, l_nz, c_op, c_lp, c_rp, c_cm, c_dig, c_let, c_oth;
  logic [6:0]       mask_new;
  logic             none_above;
  logic             num_last, let_last, fin, use_num, fn_mode;
  logic [2:0]       self_kind;

  function automatic logic [2:0] next_phase(input logic [6:0] m, input logic [2:0] cur);
    logic [2:0] nx;
    nx = S_IDLE;
    for (int i = 7; i >= 1; i--) begin
      if (m[i-1] && 3'(i) > cur) nx = 3'(i);
    end
    return nx;
  endfunction

  assign n_nz  = (sts_i.num_cnt != '0);
  assign l_nz  = (sts_i.let_cnt != '0);
  assign c_op  = (sts_i.cls == CLS_OP);
  assign c_lp  = (sts_i.cls == CLS_LPAREN);
  assign c_rp  = (sts_i.cls == CLS_RPAREN);
  assign c_cm  = (sts_i.cls == CLS_COMMA);
  assign c_dig = (sts_i.cls == CLS_DIGIT);
  assign c_let = (sts_i.cls == CLS_LETTER);
  assign c_oth = (sts_i.cls == CLS_OTHER);

  // which phases the incoming item will run, given the counts it meets
  always_comb begin
    mask_new[S_LETA-1] = (c_rp || c_lp) && l_nz;
    mask_new[S_NUM-1]  = ((c_op || c_cm || c_rp || c_let) && n_nz) || (c_lp && !l_nz && n_nz);
    mask_new[S_STAR-1] = (c_let && n_nz) || (c_lp && !l_nz && n_nz);
    mask_new[S_LETB-1] = (c_op || c_cm) && l_nz;
    mask_new[S_SELF-1] = c_op || c_lp || c_rp || c_cm;
    mask_new[S_ENUM-1] = is_end_i && (c_dig || (c_lp && l_nz && n_nz) || (c_oth && n_nz));
    mask_new[S_ELET-1] = is_end_i && (c_let || ((c_dig || c_oth) && l_nz));
  end

  assign none_above = ((mask_q >> state_q) == 7'd0);
  assign num_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == sts_i.num_cnt);
  assign let_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == sts_i.let_cnt);
  assign fn_mode    = (state_q == S_LETA) && (cls_q == CLS_LPAREN);
  assign use_num    = (state_q == S_NUM) || (state_q == S_ENUM);

  always_comb begin
    unique case (cls_q)
      CLS_LPAREN: self_kind = K_LPAREN;
      CLS_RPAREN: self_kind = K_RPAREN;
      CLS_COMMA:  self_kind = K_DELIM;
      default:    self_kind = K_OPERATOR;
    endcase
  end

  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    idx_d   = idx_q;
    star_d  = star_q;
    end_d   = end_q;
    cls_d   = cls_q;
    fin     = 1'b0;
    cmd_o   = '0;
    cmd_o.src = SRC_NUM;
    cmd_o.idx = idx_q;

    if (state_q == S_IDLE) begin
      if (in_valid_i) begin
        cmd_o.accept = 1'b1;
        mask_d  = mask_new;
        cls_d   = sts_i.cls;
        end_d   = is_end_i;
        idx_d   = '0;
        star_d  = 1'b0;
        state_d = next_phase(mask_new, S_IDLE);
        if (mask_new == 7'd0 && is_end_i) cmd_o.clr_ovf = 1'b1;
      end
    end else if (sts_i.slot_free) begin
      cmd_o.load = 1'b1;
      if (use_num) begin
        cmd_o.src      = SRC_NUM;
        cmd_o.kind     = K_LITERAL;
        cmd_o.tok_end  = num_last;
        fin            = num_last;
        cmd_o.clr_num  = num_last;
        idx_d          = idx_q + IDX_W'(1);
      end else if (state_q == S_STAR) begin
        cmd_o.src     = SRC_STAR;
        cmd_o.kind    = K_OPERATOR;
        cmd_o.tok_end = 1'b1;
        fin           = 1'b1;
      end else if (state_q == S_SELF) begin
        cmd_o.src     = SRC_SELF;
        cmd_o.kind    = self_kind;
        cmd_o.tok_end = 1'b1;
        fin           = 1'b1;
      end else if (fn_mode) begin
        cmd_o.src     = SRC_LET;
        cmd_o.kind    = K_FUNCTION;
        cmd_o.tok_end = let_last;
        fin           = let_last;
        cmd_o.clr_let = let_last;
        idx_d         = idx_q + IDX_W'(1);
      end else if (star_q) begin
        // '*' between single-letter variables
        cmd_o.src     = SRC_STAR;
        cmd_o.kind    = K_OPERATOR;
        cmd_o.tok_end = 1'b1;
        star_d        = 1'b0;
        idx_d         = idx_q + IDX_W'(1);
      end else begin
        cmd_o.src     = SRC_LET;
        cmd_o.kind    = K_VARIABLE;
        cmd_o.tok_end = 1'b1;
        fin           = let_last;
        cmd_o.clr_let = let_last;
        star_d        = !let_last;
      end

      cmd_o.run_last = fin && none_above;
      if (fin) begin
        idx_d   = '0;
        star_d  = 1'b0;
        state_d = next_phase(mask_q, state_q);
        if (none_above && end_q) cmd_o.clr_ovf = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mask_q  <= '0;
      idx_q   <= '0;
      star_q  <= 1'b0;
      end_q   <= 1'b0;
      cls_q   <= CLS_OTHER;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      idx_q   <= idx_d;
      star_q  <= star_d;
      end_q   <= end_d;
      cls_q   <= cls_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* dv/token_checker.sv */
`timescale 1ns / 100ps
// Token checker for the expression lexer: tracks the number and letter runs, predicts
// the token characters each accepted item causes and compares the result channel.
// Depends on mel_pkg for token kinds and character codes.
module token_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_char_i,
  input  logic       is_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] token_kind_i,
  input  logic [7:0] token_char_i,
  input  logic       token_end_i,
  input  logic       run_last_i,
  input  logic       truncated_i,
  output int         tokens_due_o,
  output int         mismatches_o
);
  import mel_pkg::*;

  localparam int RUN_MAX = (TOKEN_CHARS < STORE_DEPTH) ? TOKEN_CHARS : STORE_DEPTH;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       tok_end;
    logic       run_last;
    logic       truncated;
  } token_t;

  token_t     tokens_due[$];
  token_t     burst[$];
  logic [7:0] digit_run[STORE_DEPTH];
  logic [7:0] letter_run[STORE_DEPTH];
  int         digit_len;
  int         letter_len;
  logic       overflow;

  function automatic void put_token(input logic [2:0] kind, input logic [7:0] ch,
                                    input logic last);
    token_t t;
    t         = '0;
    t.kind    = kind;
    t.ch      = ch;
    t.tok_end = last;
    burst     = {burst, t};
  endfunction

  function automatic void flush_digits();
    for (int i = 0; i < digit_len; i++) put_token(K_LITERAL, digit_run[i], i == digit_len - 1);
    digit_len = 0;
  endfunction

  // pending letters become one-letter variables joined by '*'
  function automatic void flush_letters();
    for (int i = 0; i < letter_len; i++) begin
      put_token(K_VARIABLE, letter_run[i], 1'b1);
      if (i < letter_len - 1) put_token(K_OPERATOR, CH_STAR, 1'b1);
    end
    letter_len = 0;
  endfunction

  function automatic void lex_char(input logic [7:0] ch, input logic last);
    token_t t;
    burst.delete();
    if ((ch >= "0" && ch <= "9") || ch == CH_DOT) begin
      if (digit_len < RUN_MAX) begin
        digit_run[digit_len] = ch;
        digit_len++;
      end else begin
        overflow = 1'b1;
      end
    end else if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) begin
      if (digit_len != 0) begin
        flush_digits();
        put_token(K_OPERATOR, CH_STAR, 1'b1);
      end
      if (letter_len < RUN_MAX) begin
        letter_run[letter_len] = ch;
        letter_len++;
      end else begin
        overflow = 1'b1;
      end
    end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH ||
                 ch == CH_CARET) begin
      flush_digits();
      flush_letters();
      put_token(K_OPERATOR, ch, 1'b1);
    end else if (ch == CH_LPAREN) begin
      // letters win: a pending number stays pending behind a function name
      if (letter_len != 0) begin
        for (int i = 0; i < letter_len; i++)
          put_token(K_FUNCTION, letter_run[i], i == letter_len - 1);
        letter_len = 0;
      end else if (digit_len != 0) begin
        flush_digits();
        put_token(K_OPERATOR, CH_STAR, 1'b1);
      end
      put_token(K_LPAREN, ch, 1'b1);
    end else if (ch == CH_RPAREN) begin
      flush_letters();
      flush_digits();
      put_token(K_RPAREN, ch, 1'b1);
    end else if (ch == CH_COMMA) begin
      flush_digits();
      flush_letters();
      put_token(K_DELIM, ch, 1'b1);
    end
    if (last) begin
      flush_digits();
      flush_letters();
    end
    foreach (burst[k]) begin
      t           = burst[k];
      t.truncated = overflow;
      t.run_last  = (k == burst.size() - 1);
      tokens_due  = {tokens_due, t};
    end
    if (last) overflow = 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns token check: %s", $time, msg);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_t want;
    if (!rst_ni) begin
      tokens_due.delete();
      digit_len  = 0;
      letter_len = 0;
      overflow   = 1'b0;
    end else begin
      if ($isunknown(out_valid_i)) report_mismatch("out_valid_o unknown");
      if (out_valid_i && !out_stall_i) begin
        if (tokens_due.size() == 0) begin
          report_mismatch($sformatf("unexpected token char %h kind %0d",
                                    token_char_i, token_kind_i));
        end else begin
          want = tokens_due.pop_front();
          if (token_kind_i !== want.kind)
            report_mismatch($sformatf("token_kind %0d, want %0d", token_kind_i, want.kind));
          if (token_char_i !== want.ch)
            report_mismatch($sformatf("token_char %h, want %h", token_char_i, want.ch));
          if (token_end_i !== want.tok_end)
            report_mismatch($sformatf("token_end %b, want %b", token_end_i, want.tok_end));
          if (run_last_i !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b", run_last_i, want.run_last));
          if (truncated_i !== want.truncated)
            report_mismatch($sformatf("truncated %b, want %b", truncated_i, want.truncated));
        end
      end
      if (in_valid_i && !in_stall_i) lex_char(in_char_i, is_end_i);
    end
    tokens_due_o = tokens_due.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Top of the expression lexer testbench: clock, reset, character stimulus and verdict.
// Depends on mel_pkg, math_expression_lexer and token_checker.
module testbench;
  import mel_pkg::*;

  localparam int         STALL_PCT    = 25;
  localparam int         RANDOM_ITEMS = 410;
  localparam int         HANG_LIMIT   = 4000;
  localparam int         DRAIN_CYCLES = 64;
  localparam int         RUN_LONG_MIN = 14;
  localparam int         RUN_LONG_MAX = 18;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_char_i   = '0;
  logic       is_end_i    = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [2:0] token_kind_o;
  logic [7:0] token_char_o;
  logic       token_end_o;
  logic       run_last_o;
  logic       truncated_o;

  logic idle_en      = 1'b1;
  int   quiet_cycles = 0;
  int   sent         = 0;
  int   due;
  int   mismatches;

  always #6 clk_i = ~clk_i;

  math_expression_lexer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_char_i    (in_char_i),
    .is_end_i     (is_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_kind_o (token_kind_o),
    .token_char_o (token_char_o),
    .token_end_o  (token_end_o),
    .run_last_o   (run_last_o),
    .truncated_o  (truncated_o)
  );

  token_checker u_token_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_char_i    (in_char_i),
    .is_end_i     (is_end_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_kind_i (token_kind_o),
    .token_char_i (token_char_o),
    .token_end_i  (token_end_o),
    .run_last_i   (run_last_o),
    .truncated_i  (truncated_o),
    .tokens_due_o (due),
    .mismatches_o (mismatches)
  );

  always @(negedge clk_i) out_stall_i <= idle_en && ($urandom_range(99) < STALL_PCT);

  // give up when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == HANG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // returns at the clock edge that accepts the item
  task automatic put_char(input logic [7:0] ch, input logic last);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < STALL_PCT) begin
      in_valid_i <= 1'b0;
      in_char_i  <= 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= ch;
    is_end_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic feed(input logic [7:0] ch, input bit counted);
    logic last;
    last = ($urandom_range(29) == 0);
    put_char(ch, last);
    if (counted || last) sent++;
  endtask

  // a number or a letter run; now and then long enough to overflow the store
  task automatic feed_run(input bit digits);
    int         len;
    logic [7:0] ch;
    len = ($urandom_range(7) == 0) ? $urandom_range(RUN_LONG_MIN, RUN_LONG_MAX)
                                   : $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      if (digits) ch = ($urandom_range(7) == 0) ? CH_DOT : 8'("0" + $urandom_range(9));
      else ch = $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
      feed(ch, 1'b1);
    end
  endtask

  initial begin
    logic [7:0] ops[5];
    logic [7:0] blanks[3];
    string      seq;
    int         pick;
    ops    = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
    blanks = '{CH_SPACE, CH_TAB, CH_LF};
    // implied '*' after a number, function name with a number left pending,
    // ')' flushing the pending number, every operator, comma, blank
    seq    = "9.zab3()qr+7(-/*^, ";
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < seq.len(); i++) put_char(seq[i], 1'b0);
    put_char(8'h00, 1'b0);
    put_char("m", 1'b0);
    put_char("4", 1'b0);
    put_char(8'hFF, 1'b1);

    while (sent < RANDOM_ITEMS) begin
      idle_en = !(sent >= 150 && sent < 250);
      pick    = $urandom_range(99);
      if (pick < 30) feed_run(1'b1);
      else if (pick < 55) feed_run(1'b0);
      else if (pick < 70) feed(ops[$urandom_range(4)], 1'b1);
      else if (pick < 78) feed(CH_LPAREN, 1'b1);
      else if (pick < 86) feed(CH_RPAREN, 1'b1);
      else if (pick < 90) feed(CH_COMMA, 1'b1);
      else if (pick < 95) feed(blanks[$urandom_range(2)], 1'b0);
      else feed(8'($urandom), 1'b0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
